@@ rtl/core/hpa_pkg.sv @@
// Shared types and constants for the HSV pixel adjuster.
// Used by the divider cells, the recolor stage and the top level.
`timescale 1ns / 1ps

package hpa_pkg;

  localparam int unsigned DivSteps = 11;
  localparam int unsigned Latency  = DivSteps + 3;

  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_REL  = 2'd2;

  localparam logic [2:0] CFG_HUE_MODE = 3'd0;
  localparam logic [2:0] CFG_SAT_MODE = 3'd1;
  localparam logic [2:0] CFG_VAL_MODE = 3'd2;
  localparam logic [2:0] CFG_HUE_DEG  = 3'd3;
  localparam logic [2:0] CFG_SAT_SET  = 3'd4;
  localparam logic [2:0] CFG_VAL_SET  = 3'd5;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  localparam logic [12:0] HueFull  = 13'd6144;
  localparam logic [10:0] SatMax   = 11'd1024;
  localparam logic [7:0]  ValMax   = 8'd255;
  localparam logic [13:0] DegRecip = 14'd8739;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] max;
    logic [7:0] delta;
    logic [1:0] hsel;
    logic       neg;
  } side_t;

  typedef struct packed {
    logic [8:0]  rem_s;
    logic [8:0]  rem_h;
    logic [10:0] q_s;
    logic [10:0] q_h;
    side_t       side;
  } div_t;

  typedef struct packed {
    logic [1:0]  hue_mode;
    logic [1:0]  sat_mode;
    logic [1:0]  val_mode;
    logic [12:0] hue_tgt;
    logic [10:0] sat_set;
    logic [9:0]  val_set;
  } cfg_t;

endpackage

@@ rtl/core/hpa_div_cell.sv @@
// One cell of the divider chain: one quotient bit for saturation and hue.
// Depends on hpa_pkg for the cell data type.
`timescale 1ns / 1ps

module hpa_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  hpa_pkg::div_t data_i,
  output logic          valid_o,
  output hpa_pkg::div_t data_o
);

  logic          valid_q;
  hpa_pkg::div_t data_d, data_q;
  logic          ge_s, ge_h;
  logic [8:0]    nrem_s, nrem_h;

  always_comb begin
    ge_s   = data_i.rem_s >= {1'b0, data_i.side.max};
    ge_h   = data_i.rem_h >= {1'b0, data_i.side.delta};
    nrem_s = ge_s ? data_i.rem_s - {1'b0, data_i.side.max} : data_i.rem_s;
    nrem_h = ge_h ? data_i.rem_h - {1'b0, data_i.side.delta} : data_i.rem_h;
    data_d       = data_i;
    data_d.rem_s = {nrem_s[7:0], 1'b0};
    data_d.rem_h = {nrem_h[7:0], 1'b0};
    data_d.q_s   = {data_i.q_s[9:0], ge_s};
    data_d.q_h   = {data_i.q_h[9:0], ge_h};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/core/hpa_recolor.sv @@
// Applies the hue, saturation and value adjustments and converts back to RGB.
// Three registered stages; depends on hpa_pkg.
`timescale 1ns / 1ps

module hpa_recolor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  hpa_pkg::div_t data_i,
  input  hpa_pkg::cfg_t cfg_i,
  output logic          done_o,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o
);

  logic [10:0] s0;
  logic [12:0] base, h0;
  logic [13:0] hwrap, hsum;
  logic [12:0] hu;
  logic [21:0] sprod;
  logic [13:0] sscl;
  logic [17:0] vprod;
  logic [9:0]  vscl;
  logic [10:0] s1;
  logic [7:0]  v1;
  logic        pass;

  logic        v1_q, pass1_q;
  logic [23:0] rgb1_q;
  logic [2:0]  k1_q;
  logic [9:0]  f1_q;
  logic [10:0] s1_q;
  logic [7:0]  vv1_q;

  logic [10:0] fsel, sinv;
  logic [21:0] tprod;
  logic [18:0] lprod;

  logic        v2_q, pass2_q;
  logic [23:0] rgb2_q;
  logic [2:0]  k2_q;
  logic [20:0] t2_q;
  logic [7:0]  lo2_q, vv2_q;

  logic [20:0] fac;
  logic [28:0] mprod;
  logic [7:0]  mid;
  logic [7:0]  ro, go, bo;

  logic        done_q;
  logic [7:0]  red_q, green_q, blue_q;

  always_comb begin
    s0    = (data_i.side.max == 8'd0) ? 11'd0 : data_i.q_s;
    base  = {data_i.side.hsel, 11'd0};
    hwrap = {1'b0, base} + {1'b0, hpa_pkg::HueFull} - {3'b0, data_i.q_h};
    if (data_i.side.delta == 8'd0) begin
      h0 = 13'd0;
    end else if (data_i.side.neg) begin
      h0 = (hwrap >= {1'b0, hpa_pkg::HueFull}) ? 13'(hwrap - {1'b0, hpa_pkg::HueFull})
                                                : hwrap[12:0];
    end else begin
      h0 = base + {2'b0, data_i.q_h};
    end
    pass = (s0 == 11'd0) && (cfg_i.sat_mode != hpa_pkg::MODE_SET)
           && (cfg_i.sat_mode != hpa_pkg::MODE_REL);

    hsum = {1'b0, h0} + {1'b0, cfg_i.hue_tgt};
    case (cfg_i.hue_mode)
      hpa_pkg::MODE_SET: hu = cfg_i.hue_tgt;
      hpa_pkg::MODE_REL: hu = (hsum >= {1'b0, hpa_pkg::HueFull})
                              ? 13'(hsum - {1'b0, hpa_pkg::HueFull}) : hsum[12:0];
      default:           hu = h0;
    endcase

    sprod = s0 * cfg_i.sat_set;
    sscl  = sprod[21:8];
    case (cfg_i.sat_mode)
      hpa_pkg::MODE_SET: s1 = (cfg_i.sat_set > hpa_pkg::SatMax) ? hpa_pkg::SatMax
                                                                  : cfg_i.sat_set;
      hpa_pkg::MODE_REL: s1 = (sscl > {3'b0, hpa_pkg::SatMax}) ? hpa_pkg::SatMax
                                                                 : sscl[10:0];
      default:           s1 = s0;
    endcase

    vprod = data_i.side.max * cfg_i.val_set;
    vscl  = vprod[17:8];
    case (cfg_i.val_mode)
      hpa_pkg::MODE_SET: v1 = (cfg_i.val_set > {2'b0, hpa_pkg::ValMax}) ? hpa_pkg::ValMax
                                                                        : cfg_i.val_set[7:0];
      hpa_pkg::MODE_REL: v1 = (vscl > {2'b0, hpa_pkg::ValMax}) ? hpa_pkg::ValMax
                                                               : vscl[7:0];
      default:           v1 = data_i.side.max;
    endcase
  end

  always_comb begin
    sinv  = hpa_pkg::SatMax - s1_q;
    fsel  = k1_q[0] ? {1'b0, f1_q} : hpa_pkg::SatMax - {1'b0, f1_q};
    tprod = s1_q * fsel;
    lprod = vv1_q * sinv;
  end

  always_comb begin
    fac   = 21'h100000 - t2_q;
    mprod = vv2_q * fac;
    mid   = mprod[27:20];
    case (k2_q)
      3'd0:    begin ro = vv2_q; go = mid;   bo = lo2_q; end
      3'd1:    begin ro = mid;   go = vv2_q; bo = lo2_q; end
      3'd2:    begin ro = lo2_q; go = vv2_q; bo = mid;   end
      3'd3:    begin ro = lo2_q; go = mid;   bo = vv2_q; end
      3'd4:    begin ro = mid;   go = lo2_q; bo = vv2_q; end
      default: begin ro = vv2_q; go = lo2_q; bo = mid;   end
    endcase
    if (pass2_q) begin
      ro = rgb2_q[23:16];
      go = rgb2_q[15:8];
      bo = rgb2_q[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pass1_q <= pass;
    rgb1_q  <= {data_i.side.red, data_i.side.green, data_i.side.blue};
    k1_q    <= hu[12:10];
    f1_q    <= hu[9:0];
    s1_q    <= s1;
    vv1_q   <= v1;
    pass2_q <= pass1_q;
    rgb2_q  <= rgb1_q;
    k2_q    <= k1_q;
    t2_q    <= tprod[20:0];
    lo2_q   <= lprod[17:10];
    vv2_q   <= vv1_q;
    red_q   <= ro;
    green_q <= go;
    blue_q  <= bo;
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> s1_q <= hpa_pkg::SatMax) else $error("saturation out of range");
  a_sext_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> k1_q <= 3'd5) else $error("sextant out of range");
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> t2_q <= 21'h100000) else $error("sextant product out of range");

endmodule

@@ rtl/core/hsv_pixel_adjust.sv @@
// Top level of the HSV pixel adjuster: configuration registers, the
// divider cell chain and the recolor stage. Depends on hpa_pkg.
`timescale 1ns / 1ps

// One pixel is taken in every clock cycle; busy_o never rises. Each result
// appears on done_o after its start_i transfer has passed through eleven
// divider cells, one quotient bit each, then three recolor stages. Results
// cannot be held off. Configuration writes take effect from their registers,
// and a new hue angle from a second register that holds its scaled form.
module hsv_pixel_adjust (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        done_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i
);

  logic [1:0]  hue_mode_q, sat_mode_q, val_mode_q;
  logic [8:0]  hue_deg_q;
  logic [10:0] sat_set_q;
  logic [9:0]  val_set_q;
  logic [12:0] hue_tgt_q, hue_tgt_d;
  logic [22:0] qprod;
  logic [13:0] hscaled;

  logic [7:0]    mx, mn, dmag;
  logic          dneg;
  hpa_pkg::div_t head;
  hpa_pkg::cfg_t cfg;
  hpa_pkg::div_t chain_data [hpa_pkg::DivSteps+1];
  logic          chain_valid [hpa_pkg::DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_mode_q <= hpa_pkg::MODE_SET;
      sat_mode_q <= hpa_pkg::MODE_KEEP;
      val_mode_q <= hpa_pkg::MODE_KEEP;
      hue_deg_q  <= '0;
      sat_set_q  <= '0;
      val_set_q  <= '0;
      hue_tgt_q  <= '0;
    end else begin
      hue_tgt_q <= hue_tgt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hpa_pkg::CFG_HUE_MODE: hue_mode_q <= cfg_wdata_i[1:0];
          hpa_pkg::CFG_SAT_MODE: sat_mode_q <= cfg_wdata_i[1:0];
          hpa_pkg::CFG_VAL_MODE: val_mode_q <= cfg_wdata_i[1:0];
          hpa_pkg::CFG_HUE_DEG:  hue_deg_q  <= cfg_wdata_i[8:0];
          hpa_pkg::CFG_SAT_SET:  sat_set_q  <= cfg_wdata_i;
          hpa_pkg::CFG_VAL_SET:  val_set_q  <= cfg_wdata_i[9:0];
          default: ;
        endcase
      end
    end
  end

  // Degrees times 1024/60 is 17x plus x/15, the latter by reciprocal.
  always_comb begin
    qprod     = hue_deg_q * hpa_pkg::DegRecip;
    hscaled   = ({5'b0, hue_deg_q} * 14'd17) + {8'b0, qprod[22:17]};
    hue_tgt_d = (hscaled >= {1'b0, hpa_pkg::HueFull})
                ? 13'(hscaled - {1'b0, hpa_pkg::HueFull}) : hscaled[12:0];
  end

  always_comb begin
    mx = red_in_i;
    if (green_in_i > mx) mx = green_in_i;
    if (blue_in_i > mx) mx = blue_in_i;
    mn = red_in_i;
    if (green_in_i < mn) mn = green_in_i;
    if (blue_in_i < mn) mn = blue_in_i;
    head.side.red   = red_in_i;
    head.side.green = green_in_i;
    head.side.blue  = blue_in_i;
    head.side.max   = mx;
    head.side.delta = mx - mn;
    if (red_in_i == mx) begin
      head.side.hsel = hpa_pkg::SEL_RED;
      dneg = blue_in_i > green_in_i;
      dmag = dneg ? blue_in_i - green_in_i : green_in_i - blue_in_i;
    end else if (green_in_i == mx) begin
      head.side.hsel = hpa_pkg::SEL_GREEN;
      dneg = red_in_i > blue_in_i;
      dmag = dneg ? red_in_i - blue_in_i : blue_in_i - red_in_i;
    end else begin
      head.side.hsel = hpa_pkg::SEL_BLUE;
      dneg = green_in_i > red_in_i;
      dmag = dneg ? green_in_i - red_in_i : red_in_i - green_in_i;
    end
    head.side.neg = dneg;
    head.rem_s    = {1'b0, head.side.delta};
    head.rem_h    = {1'b0, dmag};
    head.q_s      = '0;
    head.q_h      = '0;
  end

  assign busy_o         = 1'b0;
  assign chain_data[0]  = head;
  assign chain_valid[0] = start_i;

  for (genvar i = 0; i < hpa_pkg::DivSteps; i++) begin : g_cell
    hpa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  assign cfg.hue_mode = hue_mode_q;
  assign cfg.sat_mode = sat_mode_q;
  assign cfg.val_mode = val_mode_q;
  assign cfg.hue_tgt  = hue_tgt_q;
  assign cfg.sat_set  = sat_set_q;
  assign cfg.val_set  = val_set_q;

  hpa_recolor u_recolor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[hpa_pkg::DivSteps]),
    .data_i  (chain_data[hpa_pkg::DivSteps]),
    .cfg_i   (cfg),
    .done_o  (done_o),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(hpa_pkg::Latency) done_o) else $error("result transfer missing");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, hpa_pkg::Latency)) else $error("result without start");
  a_hue_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hue_tgt_q < hpa_pkg::HueFull) else $error("hue target out of range");

endmodule
